// ===== sv/rcpw_pkg.sv =====
// Shared types and constants for the RC pulse width capture block.
`timescale 1ns / 1ps

package rcpw_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned NUM_CHANNELS_DEF = 6;
  localparam int unsigned TICKS_PER_US_DEF = 42;

  // Fixed field widths
  localparam int unsigned CH_W     = 3;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned WIDTH_W  = 27;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] WIDTH_MIN_RST = 16'd900;
  localparam logic [LIMIT_W-1:0] WIDTH_MAX_RST = 16'd2100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_MIN = 1'b0,
    CFG_WIDTH_MAX = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_PIN   = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OUT_RISE   = 2'd0,
    OUT_ACCEPT = 2'd1,
    OUT_REJECT = 2'd2,
    OUT_CLEAR  = 2'd3
  } outcome_e;

  typedef struct packed {
    kind_e              kind;
    logic [CH_W-1:0]    channel;
    logic               level;
    logic [STAMP_W-1:0] timestamp;
  } rcpw_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel_out;
    outcome_e           outcome;
    logic [WIDTH_W-1:0] width_measured;
    logic [LIMIT_W-1:0] stored_width;
    logic [COUNT_W-1:0] error_count;
    logic [WIDTH_W-1:0] last_bad_width;
    logic               all_in_limits;
  } rcpw_out_t;

endpackage

// ===== sv/rcpw_width_div.sv =====
// Two-step divide of a tick count by a constant: reciprocal multiply, then one correction.
`timescale 1ns / 1ps

module rcpw_width_div #(
  parameter int unsigned TICKS_PER_US = rcpw_pkg::TICKS_PER_US_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [rcpw_pkg::STAMP_W-1:0] diff_i,
  output logic [rcpw_pkg::WIDTH_W-1:0] width_o
);
  import rcpw_pkg::*;

  // floor((2^32-1)/T): the estimate lands on q or q-1
  localparam logic [STAMP_W-1:0] Recip = 32'(64'h0000_0000_FFFF_FFFF / TICKS_PER_US);
  localparam logic [9:0]         TicksW = 10'(TICKS_PER_US);

  logic [2*STAMP_W-1:0] prod;
  logic [STAMP_W-1:0]   est_q;
  logic [9:0]           lo_q;
  logic [19:0]          est_t;
  logic [9:0]           rem;
  logic                 bump;
  logic [STAMP_W-1:0]   quo;

  assign prod = {32'd0, diff_i} * {32'd0, Recip};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      est_q <= prod[2*STAMP_W-1:STAMP_W];
      lo_q  <= diff_i[9:0];
    end
  end

  // remainder is below 2T, so ten low bits are enough
  assign est_t = est_q[9:0] * TicksW;
  assign rem   = lo_q - est_t[9:0];
  assign bump  = (rem >= TicksW);
  assign quo   = est_q + {31'd0, bump};

  always_comb begin
    if (|quo[STAMP_W-1:WIDTH_W]) begin
      width_o = '1;
    end else begin
      width_o = quo[WIDTH_W-1:0];
    end
  end

endmodule

// ===== sv/rc_pulse_width_capture.sv =====
// Top level of the multi-channel RC pulse width capture block.
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// -------  ------------------------  ------------------------------------------
// config   cfg_we_i                  cfg_idx_i, cfg_wdata_i (16 bit limits)
// input    in_valid_i / in_ready_o   in_data_i  (rcpw_in_t)
// output   out_valid_o / out_ready_i out_data_o (rcpw_out_t)
//
// One beat per cycle sustained while out_ready_i is high; each result passes three register stages:
// stamp memory read, reciprocal multiply, output register.
// Reset clears all control state; stamp memory entries read as zero until written.
// Each stage advances when the one after it is free, so input keeps flowing into
// empty stages while a result waits in the output register.
// Pin beats for a channel past the last one are taken and give no result.

module rc_pulse_width_capture #(
  parameter int unsigned NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned TICKS_PER_US = rcpw_pkg::TICKS_PER_US_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rcpw_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rcpw_pkg::rcpw_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rcpw_pkg::rcpw_out_t            out_data_o
);
  import rcpw_pkg::*;

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef struct packed {
    kind_e              kind;
    logic [CH_W-1:0]    channel;
    logic               level;
    logic [STAMP_W-1:0] timestamp;
  } stage_t;

  // ---------------- configuration ----------------
  logic [LIMIT_W-1:0] width_min_q, width_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_min_q <= WIDTH_MIN_RST;
      width_max_q <= WIDTH_MAX_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH_MIN) width_min_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_WIDTH_MAX) width_max_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage enables ----------------
  logic s1_v_q, s2_v_q, out_v_q;
  logic en0, en1, en2;

  assign en2 = !out_v_q || out_ready_i;
  assign en1 = !s2_v_q || en2;
  assign en0 = !s1_v_q || en1;
  assign in_ready_o = en0;

  // ---------------- stage 0: accept, stamp memory access ----------------
  logic            acc;
  logic [7:0]      ch_ext;
  logic [IdxW-1:0] in_idx;
  logic            in_range;
  logic            pass;

  assign acc      = in_valid_i && in_ready_o;
  assign ch_ext   = {5'd0, in_data_i.channel};
  assign in_idx   = ch_ext[IdxW-1:0];
  assign in_range = ({29'd0, in_data_i.channel} < 32'(NUM_CHANNELS));
  assign pass     = (in_data_i.kind == KIND_CLEAR) || in_range;

  // Rise stamps: written on the accept edge of a rising beat, so any later beat
  // reading the same channel already sees the new value.
  logic [STAMP_W-1:0] stamp_mem [NUM_CHANNELS];
  logic [STAMP_W-1:0] rd_q;
  logic [NUM_CHANNELS-1:0] stamp_vld_q;
  logic rd_vld_q;
  logic stamp_we;

  assign stamp_we = acc && (in_data_i.kind == KIND_PIN) && in_range && in_data_i.level;

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[in_idx] <= in_data_i.timestamp;
    end
    if (acc) begin
      rd_q <= stamp_mem[in_idx];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else if (acc) begin
      rd_vld_q <= stamp_vld_q[in_idx] && in_range;
      if (stamp_we) stamp_vld_q[in_idx] <= 1'b1;
    end
  end

  // ---------------- stage 1: difference, reciprocal multiply ----------------
  stage_t s1_q, s2_q;
  logic [STAMP_W-1:0] diff;
  logic [WIDTH_W-1:0] width_us;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en0) begin
      s1_v_q <= acc && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) s1_q <= in_data_i;
  end

  // wrapping tick count since the stored rise
  assign diff = s1_q.timestamp - (rd_vld_q ? rd_q : '0);

  rcpw_width_div #(
    .TICKS_PER_US(TICKS_PER_US)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en1),
    .diff_i (diff),
    .width_o(width_us)
  );

  // ---------------- stage 2: limits, state update, result ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en1) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s2_q <= s1_q;
  end

  logic [LIMIT_W-1:0] cw_q [NUM_CHANNELS];
  logic [LIMIT_W-1:0] cw_d [NUM_CHANNELS];
  logic [COUNT_W-1:0] rej_cnt_q, rej_cnt_d;
  logic [WIDTH_W-1:0] rej_val_q, rej_val_d;
  rcpw_out_t          out_q, out_d;
  logic [7:0]         s2_ch_ext;
  logic [IdxW-1:0]    s2_idx;
  logic               fire2;
  logic               in_limits;
  logic               all_in;

  assign fire2     = s2_v_q && en2;
  assign s2_ch_ext = {5'd0, s2_q.channel};
  assign s2_idx    = s2_ch_ext[IdxW-1:0];
  assign in_limits = (width_us >= {11'd0, width_min_q}) && (width_us <= {11'd0, width_max_q});

  always_comb begin
    cw_d      = cw_q;
    rej_cnt_d = rej_cnt_q;
    rej_val_d = rej_val_q;
    out_d     = '0;
    out_d.channel_out = s2_q.channel;

    priority if (s2_q.kind == KIND_CLEAR) begin
      rej_cnt_d   = '0;
      rej_val_d   = '0;
      out_d.channel_out = '0;
      out_d.outcome = OUT_CLEAR;
    end else if (s2_q.level) begin
      out_d.outcome = OUT_RISE;
    end else if (in_limits) begin
      cw_d[s2_idx] = width_us[LIMIT_W-1:0];
      out_d.outcome = OUT_ACCEPT;
      out_d.width_measured = width_us;
    end else begin
      rej_cnt_d = rej_cnt_q + 32'd1;
      rej_val_d = width_us;
      out_d.outcome = OUT_REJECT;
      out_d.width_measured = width_us;
    end

    if (s2_q.kind == KIND_PIN) begin
      out_d.stored_width   = cw_d[s2_idx];
      out_d.error_count    = rej_cnt_d;
      out_d.last_bad_width = rej_val_d;
    end

    // strict check on the widths as they stand after this beat
    all_in = 1'b1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (cw_d[i] <= width_min_q || cw_d[i] >= width_max_q) all_in = 1'b0;
    end
    out_d.all_in_limits = all_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q      <= '{default: '0};
      rej_cnt_q <= '0;
      rej_val_q <= '0;
    end else if (fire2) begin
      cw_q      <= cw_d;
      rej_cnt_q <= rej_cnt_d;
      rej_val_q <= rej_val_d;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en2) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire2) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/rcpw_checker.sv =====
// Port-level checks for the RC pulse width capture block, bound to the top level.
`timescale 1ns / 1ps

module rcpw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input rcpw_pkg::rcpw_out_t            out_data_o
);
  import rcpw_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_CLEAR |->
      out_data_o.channel_out == '0 && out_data_o.width_measured == '0 &&
      out_data_o.stored_width == '0 && out_data_o.error_count == '0 &&
      out_data_o.last_bad_width == '0)
    else $error("clear beat carries stale statistics");

  a_rise_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_RISE |-> out_data_o.width_measured == '0)
    else $error("rise beat reports a width");

  a_accept_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_ACCEPT |->
      out_data_o.width_measured[WIDTH_W-1:LIMIT_W] == '0 &&
      out_data_o.stored_width == out_data_o.width_measured[LIMIT_W-1:0])
    else $error("accepted width not stored");

  a_reject_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_REJECT |->
      out_data_o.last_bad_width == out_data_o.width_measured)
    else $error("rejected width not kept");

endmodule

bind rc_pulse_width_capture rcpw_checker u_rcpw_checker (.*);
